// ----- rtl/ismu_pkg.sv -----
package ismu_pkg;

  // lattice size
  localparam int GRID_ROWS = 1024;
  localparam int GRID_COLS = 1024;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);

  // field widths
  localparam int ADDR_IN_W = 10;
  localparam int RAND_W    = 16;
  localparam int THR_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int ONES_W    = 4;
  localparam int LEVEL_W   = 3;

  // reciprocal reduction of the 10-bit address fields
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam int QUO_W       = ADDR_IN_W + RECIP_W - RECIP_SHIFT;
  localparam int ROW_RECIP   = (1 << RECIP_SHIFT) / GRID_ROWS;
  localparam int COL_RECIP   = (1 << RECIP_SHIFT) / GRID_COLS;

  // request queue, depth must stay a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // threshold reset values, Q1.16
  localparam logic [THR_W-1:0] ACCEPT_DE4_RST  = 17'd10901;
  localparam logic [THR_W-1:0] ACCEPT_DE8_RST  = 17'd1813;
  localparam logic [THR_W-1:0] ACCEPT_DE12_RST = 17'd302;
  localparam logic [THR_W-1:0] ACCEPT_DE16_RST = 17'd50;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DE4  = 2'd0,
    CFG_DE8  = 2'd1,
    CFG_DE12 = 2'd2,
    CFG_DE16 = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EVAL
  } bk_state_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [ADDR_IN_W-1:0] row;
    logic [ADDR_IN_W-1:0] col;
    logic                 spin_in;
    logic [RAND_W-1:0]    random;
  } in_item_t;

  typedef struct packed {
    logic spin_out;
    logic flipped;
  } out_item_t;

  // classified request as it waits in the queue
  typedef struct packed {
    op_t               kind;
    logic [ROW_W-1:0]  row_prev;
    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_prev;
    logic [COL_W-1:0]  col_cur;
    logic [COL_W-1:0]  col_next;
    logic              spin_in;
    logic [RAND_W-1:0] random;
  } q_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

// ----- rtl/ismu_front.sv -----
module ismu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ismu_pkg::in_item_t item,
  output logic               b_valid,
  input  logic               can_push,
  output ismu_pkg::q_item_t  b_item
);
  import ismu_pkg::*;

  logic                             a_valid;
  in_item_t                         a_item;
  logic [QUO_W-1:0]                 a_row_q;
  logic [QUO_W-1:0]                 a_col_q;
  logic                             b_ready;
  logic [ADDR_IN_W+RECIP_W-1:0]     row_prod;
  logic [ADDR_IN_W+RECIP_W-1:0]     col_prod;
  logic [ADDR_IN_W-1:0]             row_rem;
  logic [ADDR_IN_W-1:0]             col_rem;
  q_item_t                          b_item_next;

  assign b_ready    = !b_valid || can_push;
  assign item_ready = !a_valid || b_ready;

  // quotient estimate, at most one short of the true quotient
  assign row_prod = item.row * RECIP_W'(ROW_RECIP);
  assign col_prod = item.col * RECIP_W'(COL_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      a_item  <= item;
      a_row_q <= row_prod[ADDR_IN_W+RECIP_W-1:RECIP_SHIFT];
      a_col_q <= col_prod[ADDR_IN_W+RECIP_W-1:RECIP_SHIFT];
    end
  end

  always_comb begin
    row_rem = a_item.row - ADDR_IN_W'(a_row_q * GRID_ROWS);
    if (int'(row_rem) >= GRID_ROWS) begin
      row_rem = row_rem - ADDR_IN_W'(GRID_ROWS);
    end
    col_rem = a_item.col - ADDR_IN_W'(a_col_q * GRID_COLS);
    if (int'(col_rem) >= GRID_COLS) begin
      col_rem = col_rem - ADDR_IN_W'(GRID_COLS);
    end

    b_item_next          = '0;
    b_item_next.row_cur  = ROW_W'(row_rem);
    b_item_next.col_cur  = COL_W'(col_rem);
    b_item_next.spin_in  = a_item.spin_in;
    b_item_next.random   = a_item.random;

    // toroidal neighbours
    if (b_item_next.row_cur == '0) begin
      b_item_next.row_prev = ROW_W'(GRID_ROWS - 1);
    end else begin
      b_item_next.row_prev = b_item_next.row_cur - ROW_W'(1);
    end
    if (b_item_next.row_cur == ROW_W'(GRID_ROWS - 1)) begin
      b_item_next.row_next = '0;
    end else begin
      b_item_next.row_next = b_item_next.row_cur + ROW_W'(1);
    end
    if (b_item_next.col_cur == '0) begin
      b_item_next.col_prev = COL_W'(GRID_COLS - 1);
    end else begin
      b_item_next.col_prev = b_item_next.col_cur - COL_W'(1);
    end
    if (b_item_next.col_cur == COL_W'(GRID_COLS - 1)) begin
      b_item_next.col_next = '0;
    end else begin
      b_item_next.col_next = b_item_next.col_cur + COL_W'(1);
    end

    // unused op code behaves as a read
    case (a_item.op)
      OP_LOAD:   b_item_next.kind = OP_LOAD;
      OP_UPDATE: b_item_next.kind = OP_UPDATE;
      default:   b_item_next.kind = OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_item <= b_item_next;
    end
  end

endmodule

// ----- rtl/ismu_queue.sv -----
module ismu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              can_push,
  input  ismu_pkg::q_item_t push_item,
  output ismu_pkg::q_head_t head,
  input  logic              pop
);
  import ismu_pkg::*;

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pull;

  assign can_push   = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign push       = push_valid && can_push;
  assign pull       = pop && head.valid;
  assign head.valid = count != '0;
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pull) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pull) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pull && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/ismu_back.sv -----
module ismu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [ismu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ismu_pkg::THR_W-1:0]     cfg_data,
  input  ismu_pkg::q_head_t    head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ismu_pkg::out_item_t  result
);
  import ismu_pkg::*;

  logic [THR_W-1:0]     accept_thr [4];
  logic [GRID_COLS-1:0] spin_mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd0_data;
  logic [GRID_COLS-1:0] rd1_data;

  bk_state_t        state;
  bk_state_t        state_next;
  q_item_t          work;
  logic [2:0]       prev_bits;
  logic [2:0]       cur_bits;
  logic [2:0]       next_bits;
  logic [7:0]       nbr_bits;
  logic [ONES_W-1:0]  ones;
  logic [LEVEL_W-1:0] level;
  logic [THR_W-1:0] thr;
  logic             flip;
  logic             out_free;

  logic             rd0_en;
  logic [ROW_W-1:0] rd0_row;
  logic             rd1_en;
  logic [ROW_W-1:0] rd1_row;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic             wr_bit;
  logic             grab;
  logic             res_load;
  out_item_t        res_next;

  assign out_free = !result_valid || result_ready;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_thr[0] <= ACCEPT_DE4_RST;
      accept_thr[1] <= ACCEPT_DE8_RST;
      accept_thr[2] <= ACCEPT_DE12_RST;
      accept_thr[3] <= ACCEPT_DE16_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DE4:  accept_thr[0] <= cfg_data;
        CFG_DE8:  accept_thr[1] <= cfg_data;
        CFG_DE12: accept_thr[2] <= cfg_data;
        CFG_DE16: accept_thr[3] <= cfg_data;
        default:  ;
      endcase
    end
  end

  // spin store, one row per word, bit write
  always_ff @(posedge clk) begin
    if (rd0_en) begin
      rd0_data <= spin_mem[rd0_row];
    end
    if (rd1_en) begin
      rd1_data <= spin_mem[rd1_row];
    end
    if (wr_en) begin
      spin_mem[wr_row][wr_col] <= wr_bit;
    end
  end

  // acceptance decision
  always_comb begin
    next_bits = {rd0_data[work.col_next], rd0_data[work.col_cur],
                 rd0_data[work.col_prev]};
    nbr_bits  = {prev_bits, cur_bits[2], cur_bits[0], next_bits};
    ones      = '0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + ONES_W'(nbr_bits[i]);
    end
    level = '0;
    if (cur_bits[1] && ones > ONES_W'(4)) begin
      level = LEVEL_W'(ones - ONES_W'(4));
    end else if (!cur_bits[1] && ones < ONES_W'(4)) begin
      level = LEVEL_W'(ONES_W'(4) - ones);
    end
    case (level)
      3'd1:    thr = accept_thr[0];
      3'd2:    thr = accept_thr[1];
      3'd3:    thr = accept_thr[2];
      3'd4:    thr = accept_thr[3];
      default: thr = '0;
    endcase
    flip = (level == '0) || (thr > {1'b0, work.random});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop) begin
          case (head.item.kind)
            OP_UPDATE: state_next = BK_FETCH;
            OP_READ:   state_next = BK_EVAL;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_FETCH: state_next = BK_EVAL;
      BK_EVAL: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd0_en   = 1'b0;
    rd0_row  = work.row_next;
    rd1_en   = 1'b0;
    rd1_row  = head.item.row_cur;
    wr_en    = 1'b0;
    wr_row   = work.row_cur;
    wr_col   = work.col_cur;
    wr_bit   = !cur_bits[1];
    grab     = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    case (state)
      BK_IDLE: begin
        if (head.valid && (head.item.kind != OP_LOAD || out_free)) begin
          pop = 1'b1;
          case (head.item.kind)
            OP_LOAD: begin
              wr_en    = 1'b1;
              wr_row   = head.item.row_cur;
              wr_col   = head.item.col_cur;
              wr_bit   = head.item.spin_in;
              res_load = 1'b1;
              res_next.spin_out = head.item.spin_in;
            end
            OP_UPDATE: begin
              rd0_en  = 1'b1;
              rd0_row = head.item.row_prev;
              rd1_en  = 1'b1;
            end
            default: begin
              rd0_en  = 1'b1;
              rd0_row = head.item.row_cur;
            end
          endcase
        end
      end
      BK_FETCH: begin
        rd0_en = 1'b1;
        grab   = 1'b1;
      end
      BK_EVAL: begin
        if (out_free) begin
          res_load = 1'b1;
          if (work.kind == OP_UPDATE) begin
            wr_en             = flip;
            res_next.spin_out = cur_bits[1] ^ flip;
            res_next.flipped  = flip;
          end else begin
            res_next.spin_out = rd0_data[work.col_cur];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head.item;
    end
    if (grab) begin
      prev_bits <= {rd0_data[work.col_next], rd0_data[work.col_cur],
                    rd0_data[work.col_prev]};
      cur_bits  <= {rd1_data[work.col_next], rd1_data[work.col_cur],
                    rd1_data[work.col_prev]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

endmodule

// ----- rtl/ising_metropolis_site_update_top.sv -----
// past the front end and queue: load in IDLE, read in IDLE and EVAL, update in
// IDLE, FETCH and EVAL; one write and two read ports on the spin store; one load
// per cycle while results are taken; no pop while a read or update is in hand
// rst is synchronous, active high: clears pipeline, queue, sequencer and the
// result register, and puts the four thresholds back to their defaults
// spin store is not cleared: a cell reads as undefined until loaded
module ising_metropolis_site_update_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  ismu_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ismu_pkg::out_item_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ismu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ismu_pkg::THR_W-1:0]     cfg_data
);
  import ismu_pkg::*;

  // front end output, one classified request
  logic    b_valid;
  q_item_t b_item;
  logic    can_push;

  // queue head towards the sequencer
  q_head_t head;
  logic    pop;

  // threshold writes are always taken at once
  assign cfg_ready = 1'b1;

  // front end: wraps row and column into the lattice, works out the
  // toroidal neighbours and maps the op code, two register stages
  ismu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .b_valid    (b_valid),
    .can_push   (can_push),
    .b_item     (b_item)
  );

  // short queue so that the front end keeps taking requests while the
  // sequencer is busy with a read-modify-write
  ismu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (b_valid),
    .can_push   (can_push),
    .push_item  (b_item),
    .head       (head),
    .pop        (pop)
  );

  // back end: spin store, row fetches, neighbour sum, acceptance test,
  // write back and the result register
  ismu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/ismu_checker.sv -----
module ismu_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input ismu_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_ready,
  input ismu_pkg::out_item_t result,
  input logic                cfg_ready
);
  import ismu_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a stalled request holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("request changed while stalled");

  // reset empties the block and opens the request side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("block not empty after reset");

  // threshold writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind ising_metropolis_site_update_top ismu_checker u_checker (.*);
